>>> design/safety_interlock_supervisor_defines.svh
// Assertion macros used by the supervisor core RTL.
`ifndef SAFETY_INTERLOCK_SUPERVISOR_DEFINES_SVH
`define SAFETY_INTERLOCK_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define SIS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sis assertion failed");

// Next-cycle implication, checked at every rising clk edge outside reset.
`define SIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sis assertion failed");

`endif

>>> design/sis_pkg.sv
// Types and constants of the safety interlock supervisor.
package sis_pkg;

  typedef enum logic [2:0] {
    FuncTick      = 3'd0,
    FuncHeartbeat = 3'd1,
    FuncReset     = 3'd2,
    FuncFault     = 3'd3,
    FuncStatus    = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ReasonNone     = 3'd0,
    ReasonEstop    = 3'd1,
    ReasonDeadman  = 3'd2,
    ReasonLeak     = 3'd3,
    ReasonTimeout  = 3'd4,
    ReasonHost     = 3'd5
  } reason_t;

  typedef enum logic [1:0] {
    ResetNone     = 2'd0,
    ResetAccepted = 2'd1,
    ResetRefused  = 2'd2
  } reset_res_t;

  localparam int unsigned CfgAddrWidth = 3;
  localparam logic RegWatchdog = 1'b0;
  localparam logic RegLoop     = 1'b1;

  localparam logic [15:0] WatchdogReset = 16'd500;
  localparam logic [7:0]  LoopReset     = 8'd10;

  localparam logic [8:0]  BlinkHalf   = 9'd200;
  localparam logic [8:0]  BlinkLast   = 9'd399;
  localparam logic [10:0] ReportOk    = 11'd2000;
  localparam logic [10:0] ReportFault = 11'd1000;
  localparam logic [10:0] ReportMax   = 11'd2047;
  localparam logic [31:0] AgeMax      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] hb_timeout_ms;
    logic [7:0]  loop_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] func;
    logic       estop_ok;
    logic       deadman_ok;
    logic       leak_ok;
  } item_t;

  typedef struct packed {
    logic        contactor_enable;
    logic        fault_held;
    logic        path_ok;
    logic [31:0] heartbeat_age_ms;
    logic        fault_event;
    logic [2:0]  fault_reason;
    logic [1:0]  reset_result;
    logic [31:0] fault_total;
    logic        status_led;
    logic        status_report;
  } res_t;

endpackage

>>> design/sis_if.sv
// Valid/ready channel interfaces for supervisor items and results.
interface sis_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic       estop_ok;
  logic       deadman_ok;
  logic       leak_ok;

  modport source (output valid, func, estop_ok, deadman_ok, leak_ok, input ready);
  modport sink (input valid, func, estop_ok, deadman_ok, leak_ok, output ready);
endinterface

interface sis_out_if;
  logic        valid;
  logic        ready;
  logic        contactor_enable;
  logic        fault_held;
  logic        path_ok;
  logic [31:0] heartbeat_age_ms;
  logic        fault_event;
  logic [2:0]  fault_reason;
  logic [1:0]  reset_result;
  logic [31:0] fault_total;
  logic        status_led;
  logic        status_report;

  modport source (
    output valid, contactor_enable, fault_held, path_ok, heartbeat_age_ms,
           fault_event, fault_reason, reset_result, fault_total, status_led,
           status_report,
    input  ready
  );
  modport sink (
    input  valid, contactor_enable, fault_held, path_ok, heartbeat_age_ms,
           fault_event, fault_reason, reset_result, fault_total, status_led,
           status_report,
    output ready
  );
endinterface

>>> design/sis_core.sv
// Supervisor state and its per-transaction update logic.
`include "safety_interlock_supervisor_defines.svh"

module sis_core (
  input  logic          clk,
  input  logic          rst_n,
  input  sis_pkg::cfg_t  cfg,
  input  sis_pkg::item_t item,
  input  logic          advance,
  output sis_pkg::res_t  res
);
  import sis_pkg::*;

  logic        latch_r, latch_nxt;
  logic [31:0] hb_age_r, hb_age_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] fault_cnt_r, fault_cnt_nxt;
  logic        contactor_r, contactor_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic [8:0]  blink_r, blink_nxt;
  logic [10:0] rpt_r, rpt_nxt;

  logic       raise;
  logic       eval;
  logic       ok;
  logic       report;
  reason_t    reason;
  reset_res_t rst_res;

  always_comb begin
    latch_nxt     = latch_r;
    hb_age_nxt    = hb_age_r;
    armed_nxt     = armed_r;
    fault_cnt_nxt = fault_cnt_r;
    contactor_nxt = contactor_r;
    phase_nxt     = phase_r;
    blink_nxt     = blink_r;
    rpt_nxt       = rpt_r;
    raise         = 1'b0;
    eval          = 1'b0;
    report        = 1'b0;
    reason        = ReasonNone;
    rst_res       = ResetNone;

    case (item.func)
      FuncTick: begin
        hb_age_nxt = (hb_age_r == AgeMax) ? hb_age_r : hb_age_r + 32'd1;
        blink_nxt  = (blink_r >= BlinkLast) ? 9'd0 : blink_r + 9'd1;
        rpt_nxt    = (rpt_r == ReportMax) ? rpt_r : rpt_r + 11'd1;
        phase_nxt  = phase_r + 8'd1;
        if (phase_nxt >= cfg.loop_period_ms) begin
          phase_nxt = 8'd0;
          eval      = 1'b1;
          if (!item.estop_ok) begin
            raise  = 1'b1;
            reason = ReasonEstop;
          end else if (!item.deadman_ok) begin
            raise  = 1'b1;
            reason = ReasonDeadman;
          end else if (!item.leak_ok) begin
            raise  = 1'b1;
            reason = ReasonLeak;
          end else if (!(hb_age_nxt < {16'd0, cfg.hb_timeout_ms}) && !latch_r
                       && armed_r) begin
            raise  = 1'b1;
            reason = ReasonTimeout;
          end
        end
      end
      FuncHeartbeat: begin
        hb_age_nxt = 32'd0;
        armed_nxt  = 1'b1;
      end
      FuncReset: begin
        if (item.estop_ok) begin
          latch_nxt  = 1'b0;
          hb_age_nxt = 32'd0;
          armed_nxt  = 1'b1;
          rst_res    = ResetAccepted;
        end else begin
          rst_res = ResetRefused;
        end
      end
      FuncFault: begin
        raise  = 1'b1;
        reason = ReasonHost;
      end
      FuncStatus: report = 1'b1;
      default: ;
    endcase

    // count only clear-to-set transitions of the latch
    if (raise) begin
      if (!latch_r) begin
        fault_cnt_nxt = fault_cnt_r + 32'd1;
      end
      latch_nxt     = 1'b1;
      contactor_nxt = 1'b0;
    end

    ok = item.estop_ok && item.deadman_ok && item.leak_ok
         && (hb_age_nxt < {16'd0, cfg.hb_timeout_ms}) && !latch_nxt;

    if (eval) begin
      contactor_nxt = ok;
      if (rpt_nxt >= (ok ? ReportOk : ReportFault)) begin
        rpt_nxt = 11'd0;
        report  = 1'b1;
      end
    end

    res.contactor_enable = contactor_nxt;
    res.fault_held       = latch_nxt;
    res.path_ok          = ok;
    res.heartbeat_age_ms = hb_age_nxt;
    res.fault_event      = raise;
    res.fault_reason     = reason;
    res.reset_result     = rst_res;
    res.fault_total      = fault_cnt_nxt;
    res.status_led       = contactor_nxt || (blink_nxt >= BlinkHalf);
    res.status_report    = report;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r     <= 1'b1;
      hb_age_r    <= 32'd0;
      armed_r     <= 1'b0;
      fault_cnt_r <= 32'd0;
      contactor_r <= 1'b0;
      phase_r     <= 8'd0;
      blink_r     <= 9'd0;
      rpt_r       <= 11'd0;
    end else if (advance) begin
      latch_r     <= latch_nxt;
      hb_age_r    <= hb_age_nxt;
      armed_r     <= armed_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      contactor_r <= contactor_nxt;
      phase_r     <= phase_nxt;
      blink_r     <= blink_nxt;
      rpt_r       <= rpt_nxt;
    end
  end

  `SIS_ASSERT_NOW(a_event_sets_latch, advance && res.fault_event, res.fault_held)
  `SIS_ASSERT_NOW(a_contactor_needs_clear, contactor_r, !latch_r)
  `SIS_ASSERT_NEXT(a_count_steps_by_one, 1'b1, (fault_cnt_r - $past(fault_cnt_r)) <= 32'd1)
  `SIS_ASSERT_NOW(a_blink_in_range, 1'b1, blink_r <= BlinkLast)

endmodule

>>> design/safety_interlock_supervisor.sv
// Throughput: one transaction per cycle; the input register feeds the update
// logic, whose result lands in an output register; input ready falls only while
// both registers hold a transaction and the result is not being taken.
// Reset (rst_n low, synchronous): fault latch set, all counters and timers zero,
// heartbeat unarmed, contactor off, registers at 500 ms timeout and 10 ms period.
module safety_interlock_supervisor (
  input  logic                                   clk,
  input  logic                                   rst_n,
  sis_in_if.sink                                 in_ch,
  sis_out_if.source                              out_ch,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [sis_pkg::CfgAddrWidth-1:0]       paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import sis_pkg::*;

  cfg_t  cfg_r;
  item_t item_r;
  logic  in_v_r;
  res_t  res;
  res_t  res_r;
  logic  out_v_r;
  logic  advance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hb_timeout_ms  <= WatchdogReset;
      cfg_r.loop_period_ms <= LoopReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegWatchdog: cfg_r.hb_timeout_ms  <= pwdata[15:0];
        RegLoop:     cfg_r.loop_period_ms <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegWatchdog: prdata = {16'd0, cfg_r.hb_timeout_ms};
      RegLoop:     prdata = {24'd0, cfg_r.loop_period_ms};
      default:     prdata = 32'd0;
    endcase
  end

  // move the held transaction on when the result register frees up
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.func       <= in_ch.func;
      item_r.estop_ok   <= in_ch.estop_ok;
      item_r.deadman_ok <= in_ch.deadman_ok;
      item_r.leak_ok    <= in_ch.leak_ok;
    end
  end

  sis_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item    (item_r),
    .advance (advance),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.contactor_enable = res_r.contactor_enable;
  assign out_ch.fault_held       = res_r.fault_held;
  assign out_ch.path_ok          = res_r.path_ok;
  assign out_ch.heartbeat_age_ms = res_r.heartbeat_age_ms;
  assign out_ch.fault_event      = res_r.fault_event;
  assign out_ch.fault_reason     = res_r.fault_reason;
  assign out_ch.reset_result     = res_r.reset_result;
  assign out_ch.fault_total      = res_r.fault_total;
  assign out_ch.status_led       = res_r.status_led;
  assign out_ch.status_report    = res_r.status_report;

endmodule
